/* design/multi_pool_block_allocator_assert.svh */
// Assertion macros used by the allocator controller.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MULTI_POOL_BLOCK_ALLOCATOR_ASSERT_SVH
`define MULTI_POOL_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define MPBA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, checked out of reset only.
`define MPBA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

/* design/mpba_pkg.sv */
// Shared types and constants for the multi-pool block allocator.
// No dependencies; used by the controller, datapath and top level.
package mpba_pkg;

  localparam int CMD_W      = 2;
  localparam int SIZE_W     = 16;
  localparam int BADDR_W    = 16;
  localparam int AADDR_W    = 14;
  localparam int STATUS_W   = 2;
  localparam int LOG_W      = 4;
  localparam int CNT_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Largest block count a single pool may hold
  localparam logic [CNT_W-1:0] CNT_MAX = 9'd256;

  // Pools backed by configuration registers; further pools are fixed
  localparam int NUM_CFG_POOLS = 4;
  localparam logic [LOG_W-1:0] SPARE_LOG2 = 4'd12;

  // Register values after reset, pool 0 in the low slot
  localparam logic [NUM_CFG_POOLS-1:0][LOG_W-1:0] RST_LOG2 = {4'd8, 4'd7, 4'd6, 4'd5};
  localparam logic [NUM_CFG_POOLS-1:0][CNT_W-1:0] RST_COUNT =
    {9'd16, 9'd32, 9'd64, 9'd128};

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_INIT  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_INVAL  = 2'd1,
    ST_FULL   = 2'd2,
    ST_LAYOUT = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOG2_0 = 3'd0,
    REG_LOG2_1 = 3'd1,
    REG_LOG2_2 = 3'd2,
    REG_LOG2_3 = 3'd3,
    REG_CNT_0  = 3'd4,
    REG_CNT_1  = 3'd5,
    REG_CNT_2  = 3'd6,
    REG_CNT_3  = 3'd7
  } reg_e;

  typedef enum logic [4:0] {
    S_CLR   = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep_en;
    logic sweep_fill;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_init;
    logic init_ok;
    logic sweep_last;
  } dp_sts_t;

endpackage

/* design/mpba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mpba_datapath.sv */
// Allocator datapath: config and layout registers, stack fills, pool search,
// address locate, free stack and free bitmap RAMs, result register.
// Depends on mpba_pkg and mpba_ram.
module mpba_datapath #(
  parameter int NUM_POOLS  = 4,
  parameter int HEAP_BYTES = 16384,
  parameter int MAX_BLOCKS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mpba_pkg::ctrl_cmd_t                 ctrl_i,
  output mpba_pkg::dp_sts_t                   sts_o,
  input  logic [mpba_pkg::CMD_W-1:0]          cmd_i,
  input  logic [mpba_pkg::SIZE_W-1:0]         req_size_i,
  input  logic [mpba_pkg::BADDR_W-1:0]        block_addr_i,
  input  logic                                cfg_we_i,
  input  logic [mpba_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mpba_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic [mpba_pkg::STATUS_W-1:0]       status_o,
  output logic [mpba_pkg::AADDR_W-1:0]        alloc_addr_o,
  output logic                                block_is_free_o
);

  localparam int BLK_W  = $clog2(MAX_BLOCKS);
  localparam int NB_W   = $clog2(MAX_BLOCKS + 1);
  localparam int WW     = NB_W + 2;
  localparam int ADDR_W = $clog2(HEAP_BYTES + 1);
  localparam int POOL_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int LOG_W  = mpba_pkg::LOG_W;
  localparam int CNT_W  = mpba_pkg::CNT_W;
  localparam int AA_W   = mpba_pkg::AADDR_W;

  typedef logic [NUM_POOLS-1:0][LOG_W-1:0]  log_arr_t;
  typedef logic [NUM_POOLS-1:0][CNT_W-1:0]  cnt_arr_t;
  typedef logic [NUM_POOLS-1:0][NB_W-1:0]   base_arr_t;
  typedef logic [NUM_POOLS-1:0][ADDR_W-1:0] start_arr_t;

  // Layout check: every count in range, bytes match the heap, blocks fit
  function automatic logic layout_ok(input log_arr_t l, input cnt_arr_t c);
    logic [27:0] bytes;
    logic [12:0] blocks;
    logic        ok;
    bytes  = '0;
    blocks = '0;
    ok     = 1'b1;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (c[p] > mpba_pkg::CNT_MAX) ok = 1'b0;
      bytes  = bytes + (28'(c[p]) << l[p]);
      blocks = blocks + 13'(c[p]);
    end
    return ok && (bytes == 28'(HEAP_BYTES)) && (blocks <= 13'(MAX_BLOCKS));
  endfunction

  function automatic base_arr_t calc_base(input cnt_arr_t c);
    base_arr_t   b;
    logic [12:0] acc;
    acc = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      b[p] = NB_W'(acc);
      acc  = acc + 13'(c[p]);
    end
    return b;
  endfunction

  function automatic start_arr_t calc_start(input log_arr_t l, input cnt_arr_t c);
    start_arr_t  s;
    logic [27:0] acc;
    acc = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      s[p] = ADDR_W'(acc);
      acc  = acc + (28'(c[p]) << l[p]);
    end
    return s;
  endfunction

  function automatic logic [NB_W-1:0] calc_total(input cnt_arr_t c);
    logic [12:0] acc;
    acc = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      acc = acc + 13'(c[p]);
    end
    return NB_W'(acc);
  endfunction

  function automatic log_arr_t rst_log2_f();
    log_arr_t r;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (p < mpba_pkg::NUM_CFG_POOLS) r[p] = mpba_pkg::RST_LOG2[p];
      else r[p] = mpba_pkg::SPARE_LOG2;
    end
    return r;
  endfunction

  function automatic cnt_arr_t rst_cnt_f();
    cnt_arr_t r;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (p < mpba_pkg::NUM_CFG_POOLS) r[p] = mpba_pkg::RST_COUNT[p];
      else r[p] = '0;
    end
    return r;
  endfunction

  // Layout latched at reset: the reset registers if they form a good layout
  localparam log_arr_t   RST_L     = rst_log2_f();
  localparam cnt_arr_t   RST_C     = rst_cnt_f();
  localparam logic       RST_OK    = layout_ok(RST_L, RST_C);
  localparam log_arr_t   LAY_L0    = RST_OK ? RST_L : '0;
  localparam cnt_arr_t   LAY_C0    = RST_OK ? RST_C : '0;
  localparam base_arr_t  LAY_B0    = calc_base(LAY_C0);
  localparam start_arr_t LAY_S0    = calc_start(LAY_L0, LAY_C0);
  localparam logic [NB_W-1:0] LAY_T0 = calc_total(LAY_C0);

  // Registers
  mpba_pkg::cmd_e                                          cmd_q;
  logic [mpba_pkg::SIZE_W-1:0]                             size_q;
  logic [mpba_pkg::BADDR_W-1:0]                            baddr_q;
  logic [mpba_pkg::NUM_CFG_POOLS-1:0][LOG_W-1:0]           cfg_log2_q;
  logic [mpba_pkg::NUM_CFG_POOLS-1:0][CNT_W-1:0]           cfg_cnt_q;
  log_arr_t                                                lay_log2_q;
  cnt_arr_t                                                lay_cnt_q;
  base_arr_t                                               lay_base_q;
  start_arr_t                                              lay_start_q;
  logic [NB_W-1:0]                                         total_q;
  cnt_arr_t                                                fill_q;
  logic [BLK_W-1:0]                                        sw_q;
  mpba_pkg::status_e                                       out_status_q;
  logic [AA_W-1:0]                                         out_addr_q;
  logic                                                    out_free_q;

  log_arr_t cfg_l;
  cnt_arr_t cfg_c;
  logic     cfg_ok;

  // Register view of every pool; pools past the register set are fixed
  for (genvar p = 0; p < NUM_POOLS; p++) begin : g_cfg
    if (p < mpba_pkg::NUM_CFG_POOLS) begin : g_reg
      assign cfg_l[p] = cfg_log2_q[p];
      assign cfg_c[p] = cfg_cnt_q[p];
    end else begin : g_spare
      assign cfg_l[p] = mpba_pkg::SPARE_LOG2;
      assign cfg_c[p] = '0;
    end
  end

  assign cfg_ok = layout_ok(cfg_l, cfg_c);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_log2_q <= mpba_pkg::RST_LOG2;
      cfg_cnt_q  <= mpba_pkg::RST_COUNT;
    end else if (cfg_we_i) begin
      case (mpba_pkg::reg_e'(cfg_idx_i))
        mpba_pkg::REG_LOG2_0: cfg_log2_q[0] <= cfg_wdata_i[LOG_W-1:0];
        mpba_pkg::REG_LOG2_1: cfg_log2_q[1] <= cfg_wdata_i[LOG_W-1:0];
        mpba_pkg::REG_LOG2_2: cfg_log2_q[2] <= cfg_wdata_i[LOG_W-1:0];
        mpba_pkg::REG_LOG2_3: cfg_log2_q[3] <= cfg_wdata_i[LOG_W-1:0];
        mpba_pkg::REG_CNT_0:  cfg_cnt_q[0]  <= cfg_wdata_i[CNT_W-1:0];
        mpba_pkg::REG_CNT_1:  cfg_cnt_q[1]  <= cfg_wdata_i[CNT_W-1:0];
        mpba_pkg::REG_CNT_2:  cfg_cnt_q[2]  <= cfg_wdata_i[CNT_W-1:0];
        mpba_pkg::REG_CNT_3:  cfg_cnt_q[3]  <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Command capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q   <= mpba_pkg::cmd_e'(cmd_i);
      size_q  <= req_size_i;
      baddr_q <= block_addr_i;
    end
  end

  // Allocate: first fitting pool, then first non-empty pool from there on
  logic [NUM_POOLS-1:0][16:0] pw;
  logic                       any_fit;
  logic                       found;
  logic [POOL_W-1:0]          sel;
  logic                       size_bad;
  mpba_pkg::status_e          alloc_st;
  logic [BLK_W-1:0]           alloc_slot;

  for (genvar p = 0; p < NUM_POOLS; p++) begin : g_pw
    assign pw[p] = 17'(1) << lay_log2_q[p];
  end

  always_comb begin
    any_fit = 1'b0;
    found   = 1'b0;
    sel     = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (!found && (any_fit || (17'(size_q) <= pw[p]))) begin
        any_fit = 1'b1;
        if (fill_q[p] != '0) begin
          found = 1'b1;
          sel   = POOL_W'(p);
        end
      end
    end
  end

  assign size_bad   = (size_q == '0) || (17'(size_q) > pw[NUM_POOLS-1]);
  assign alloc_st   = (size_bad || !any_fit) ? mpba_pkg::ST_INVAL :
                      (!found ? mpba_pkg::ST_FULL : mpba_pkg::ST_OK);
  assign alloc_slot = BLK_W'(WW'(lay_base_q[sel]) + WW'(fill_q[sel]) - WW'(1));

  // Locate: pool holding the byte offset, global block and offset in block
  logic                     in_heap;
  logic                     any_hit;
  logic [POOL_W-1:0]        loc_pool;
  logic [15:0]              loc_rel;
  logic [17:0]              g_full;
  logic [15:0]              loc_off;
  logic                     loc_ok;
  logic [BLK_W-1:0]         loc_g;

  always_comb begin
    logic [16:0] rel;
    logic [23:0] len;
    any_hit  = 1'b0;
    loc_pool = '0;
    loc_rel  = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      rel = 17'(baddr_q) - 17'(lay_start_q[p]);
      len = 24'(lay_cnt_q[p]) << lay_log2_q[p];
      if (!any_hit && (17'(baddr_q) >= 17'(lay_start_q[p])) && (24'(rel) < len)) begin
        any_hit  = 1'b1;
        loc_pool = POOL_W'(p);
        loc_rel  = rel[15:0];
      end
    end
  end

  assign in_heap = 17'(baddr_q) < 17'(HEAP_BYTES);
  assign g_full  = 18'(lay_base_q[loc_pool]) + 18'(loc_rel >> lay_log2_q[loc_pool]);
  assign loc_off = loc_rel & ((16'(1) << lay_log2_q[loc_pool]) - 16'(1));
  assign loc_ok  = in_heap && any_hit && (g_full < 18'(MAX_BLOCKS));
  assign loc_g   = g_full[BLK_W-1:0];

  // RAMs
  logic             stk_we;
  logic [BLK_W-1:0] stk_waddr;
  logic [BLK_W-1:0] stk_wdata;
  logic [BLK_W-1:0] stk_rd;
  logic             bm_we;
  logic [BLK_W-1:0] bm_waddr;
  logic             bm_wdata;
  logic             bm_rd;

  mpba_ram #(.WIDTH(BLK_W), .DEPTH(MAX_BLOCKS)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (alloc_slot),
    .rdata_o (stk_rd)
  );

  mpba_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (loc_g),
    .rdata_o (bm_rd)
  );

  // Final result, using the RAM data read in the execute cycle
  logic              alloc_ok;
  logic              free_ok;
  logic [AA_W-1:0]   alloc_addr;
  mpba_pkg::status_e fin_st;
  logic              fin_free;
  logic [BLK_W-1:0]  push_slot;

  assign alloc_ok   = (cmd_q == mpba_pkg::CMD_ALLOC) && (alloc_st == mpba_pkg::ST_OK);
  assign free_ok    = (cmd_q == mpba_pkg::CMD_FREE) && loc_ok && (loc_off == '0) && !bm_rd
                      && (fill_q[loc_pool] < lay_cnt_q[loc_pool]);
  assign alloc_addr = AA_W'(lay_start_q[sel])
                      + (AA_W'(WW'(stk_rd) - WW'(lay_base_q[sel])) << lay_log2_q[sel]);
  assign push_slot  = BLK_W'(WW'(lay_base_q[loc_pool]) + WW'(fill_q[loc_pool]));

  always_comb begin
    fin_st   = mpba_pkg::ST_OK;
    fin_free = 1'b0;
    case (cmd_q)
      mpba_pkg::CMD_ALLOC: fin_st = alloc_st;
      mpba_pkg::CMD_FREE:  fin_st = free_ok ? mpba_pkg::ST_OK : mpba_pkg::ST_INVAL;
      mpba_pkg::CMD_QUERY: begin
        fin_st   = loc_ok ? mpba_pkg::ST_OK : mpba_pkg::ST_INVAL;
        fin_free = loc_ok && bm_rd;
      end
      mpba_pkg::CMD_INIT:  fin_st = cfg_ok ? mpba_pkg::ST_OK : mpba_pkg::ST_LAYOUT;
      default: fin_st = mpba_pkg::ST_INVAL;
    endcase
  end

  // Sweep: clear the bitmap, or rebuild stacks and bitmap after init
  logic             sw_live;
  logic [BLK_W-1:0] sw_val;

  assign sw_live = ctrl_i.sweep_fill && (WW'(sw_q) < WW'(total_q));

  always_comb begin
    logic hit;
    hit    = 1'b0;
    sw_val = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (!hit && (WW'(sw_q) >= WW'(lay_base_q[p]))
          && (WW'(sw_q) < WW'(lay_base_q[p]) + WW'(lay_cnt_q[p]))) begin
        hit    = 1'b1;
        sw_val = BLK_W'(WW'(lay_base_q[p]) + WW'(lay_base_q[p]) + WW'(lay_cnt_q[p])
                        - WW'(1) - WW'(sw_q));
      end
    end
  end

  // RAM write ports: sweep or command commit
  always_comb begin
    if (ctrl_i.sweep_en) begin
      stk_we    = sw_live;
      stk_waddr = sw_q;
      stk_wdata = sw_val;
      bm_we     = 1'b1;
      bm_waddr  = sw_q;
      bm_wdata  = sw_live;
    end else begin
      stk_we    = ctrl_i.commit && free_ok;
      stk_waddr = push_slot;
      stk_wdata = loc_g;
      bm_we     = ctrl_i.commit && (alloc_ok || free_ok);
      bm_waddr  = alloc_ok ? stk_rd : loc_g;
      bm_wdata  = free_ok;
    end
  end

  // Sweep counter
  assign sts_o.sweep_last = (sw_q == BLK_W'(MAX_BLOCKS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= '0;
    end else if (ctrl_i.sweep_en) begin
      sw_q <= sts_o.sweep_last ? '0 : sw_q + BLK_W'(1);
    end
  end

  // Layout and stack fills; a good init latches in the execute cycle,
  // so the sweep that follows already sees the new layout
  logic exec_q;
  logic latch;
  assign latch = exec_q && (cmd_q == mpba_pkg::CMD_INIT) && cfg_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lay_log2_q  <= LAY_L0;
      lay_cnt_q   <= LAY_C0;
      lay_base_q  <= LAY_B0;
      lay_start_q <= LAY_S0;
      total_q     <= LAY_T0;
      fill_q      <= '0;
      exec_q      <= 1'b0;
    end else begin
      exec_q <= ctrl_i.accept;
      if (latch) begin
        lay_log2_q  <= cfg_l;
        lay_cnt_q   <= cfg_c;
        lay_base_q  <= calc_base(cfg_c);
        lay_start_q <= calc_start(cfg_l, cfg_c);
        total_q     <= calc_total(cfg_c);
        fill_q      <= cfg_c;
      end else if (ctrl_i.commit && alloc_ok) begin
        fill_q[sel] <= fill_q[sel] - CNT_W'(1);
      end else if (ctrl_i.commit && free_ok) begin
        fill_q[loc_pool] <= fill_q[loc_pool] + CNT_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      out_status_q <= fin_st;
      out_addr_q   <= alloc_ok ? alloc_addr : '0;
      out_free_q   <= fin_free;
    end
  end

  assign sts_o.is_init   = (cmd_q == mpba_pkg::CMD_INIT);
  assign sts_o.init_ok   = cfg_ok;
  assign status_o        = out_status_q;
  assign alloc_addr_o    = out_addr_q;
  assign block_is_free_o = out_free_q;

endmodule

/* design/mpba_ctrl.sv */
// Allocator controller: clearing pass, accept, execute, sweep, commit.
// Depends on mpba_pkg and the assertion macro header.
`include "multi_pool_block_allocator_assert.svh"

module mpba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mpba_pkg::dp_sts_t   sts_i,
  output mpba_pkg::ctrl_cmd_t cmd_o
);

  mpba_pkg::state_e state_q, state_d;
  logic             out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpba_pkg::S_CLR: begin
        if (sts_i.sweep_last) state_d = mpba_pkg::S_IDLE;
      end
      mpba_pkg::S_IDLE: begin
        if (in_valid_i) state_d = mpba_pkg::S_EXEC;
      end
      mpba_pkg::S_EXEC: begin
        state_d = (sts_i.is_init && sts_i.init_ok) ? mpba_pkg::S_SWEEP : mpba_pkg::S_FIN;
      end
      mpba_pkg::S_SWEEP: begin
        if (sts_i.sweep_last) state_d = mpba_pkg::S_FIN;
      end
      mpba_pkg::S_FIN: begin
        if (cmd_o.commit) state_d = mpba_pkg::S_IDLE;
      end
      default: state_d = mpba_pkg::S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpba_pkg::S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands to the datapath
  assign in_ready_o       = (state_q == mpba_pkg::S_IDLE);
  assign cmd_o.accept     = in_ready_o && in_valid_i;
  assign cmd_o.sweep_en   = (state_q == mpba_pkg::S_CLR) || (state_q == mpba_pkg::S_SWEEP);
  assign cmd_o.sweep_fill = (state_q == mpba_pkg::S_SWEEP);
  assign cmd_o.commit     = (state_q == mpba_pkg::S_FIN) && (!out_valid_q || out_ready_i);

  // Result beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_o.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `MPBA_ASSERT_NXT(a_accept_exec, cmd_o.accept, state_q == mpba_pkg::S_EXEC)
  `MPBA_ASSERT_NXT(a_exec_fin, state_q == mpba_pkg::S_EXEC && !sts_i.is_init, state_q == mpba_pkg::S_FIN)
  `MPBA_ASSERT_NXT(a_commit_valid, cmd_o.commit, out_valid_o)
  `MPBA_ASSERT_IMP(a_sweep_no_accept, cmd_o.sweep_en, !in_ready_o && !cmd_o.commit)

endmodule

/* design/multi_pool_block_allocator.sv */
// Top level of the segregated fixed-size pool allocator.
// Depends on mpba_pkg, mpba_ctrl, mpba_datapath (and mpba_ram below it).
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, cmd, req_size,    | to block
//           | block_addr                               |
//   out     | out_valid_o/out_ready_i, status,         | from block
//           | alloc_addr, block_is_free                |
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i         | to block
//
// Allocate, free and query go through accept, an execute step for the
// registered read of the free stack and bitmap RAMs, then commit.
// A successful init adds a sweep over both RAMs.
// After reset, a clearing pass runs over the bitmap with in_ready_o low;
// config writes are taken throughout.
// A result beat waiting on out_ready_i holds the commit cycle.
module multi_pool_block_allocator #(
  parameter int NUM_POOLS  = 4,
  parameter int HEAP_BYTES = 16384,
  parameter int MAX_BLOCKS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mpba_pkg::CMD_W-1:0]          cmd_i,
  input  logic [mpba_pkg::SIZE_W-1:0]         req_size_i,
  input  logic [mpba_pkg::BADDR_W-1:0]        block_addr_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mpba_pkg::STATUS_W-1:0]       status_o,
  output logic [mpba_pkg::AADDR_W-1:0]        alloc_addr_o,
  output logic                                block_is_free_o,
  input  logic                                cfg_we_i,
  input  logic [mpba_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mpba_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  mpba_pkg::ctrl_cmd_t ctrl;
  mpba_pkg::dp_sts_t   sts;

  mpba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (ctrl)
  );

  mpba_datapath #(
    .NUM_POOLS  (NUM_POOLS),
    .HEAP_BYTES (HEAP_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .sts_o           (sts),
    .cmd_i           (cmd_i),
    .req_size_i      (req_size_i),
    .block_addr_i    (block_addr_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .status_o        (status_o),
    .alloc_addr_o    (alloc_addr_o),
    .block_is_free_o (block_is_free_o)
  );

endmodule

/* bench/tb_multi_pool_block_allocator.sv */
// Self-checking bench for multi_pool_block_allocator: a pool-layout predictor
// plus a small scoreboard class. Needs mpba_pkg and the allocator RTL only.
module tb_multi_pool_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import mpba_pkg::*;

  localparam int unsigned HEAP  = 16384;
  localparam int unsigned NBLK  = 256;
  localparam int          WDOG  = 5000;

  typedef struct packed {
    status_e          st;
    logic [AADDR_W-1:0] aa;
    logic             fr;
  } alloc_result_t;

  // Holds predicted result beats and checks them in order
  class alloc_scoreboard;
    alloc_result_t pend[$];
    int errors = 0;
    int n_chk = 0;

    function void note(alloc_result_t r);
      pend.push_back(r);
    endfunction

    function void check(alloc_result_t a);
      alloc_result_t e;
      n_chk++;
      if (pend.size() == 0) begin
        $display("%0t: unexpected beat status=%0d addr=%0d free=%0d",
                 $time, a.st, a.aa, a.fr);
        errors++;
        return;
      end
      e = pend.pop_front();
      if (e.st !== a.st) begin
        $display("%0t: status exp %0d got %0d", $time, e.st, a.st);
        errors++;
      end
      if (e.aa !== a.aa) begin
        $display("%0t: alloc_addr exp %0d got %0d", $time, e.aa, a.aa);
        errors++;
      end
      if (e.fr !== a.fr) begin
        $display("%0t: block_is_free exp %0d got %0d", $time, e.fr, a.fr);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  cmd_e cmd = CMD_QUERY;
  logic [SIZE_W-1:0] req_size = '0;
  logic [BADDR_W-1:0] block_addr = '0;
  logic in_ready, out_valid, blk_free;
  logic [STATUS_W-1:0] status;
  logic [AADDR_W-1:0] alloc_addr;
  logic cfg_we = 0;
  reg_e cfg_idx = REG_LOG2_0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  multi_pool_block_allocator i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .req_size_i(req_size), .block_addr_i(block_addr),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .alloc_addr_o(alloc_addr), .block_is_free_o(blk_free),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  alloc_scoreboard sb = new();

  // Predictor state: registers, latched layout, stacks and bitmap
  logic [LOG_W-1:0] reg_lg[4];
  logic [CNT_W-1:0] reg_cnt[4];
  int unsigned lay_lg[4], lay_cnt[4], lay_base[4], lay_start[4];
  int unsigned fill[4];
  int unsigned stk[NBLK];
  bit bmap[NBLK];
  int unsigned live_addrs[$];

  function automatic bit latch_layout();
    int unsigned bytes = 0, blocks = 0;
    for (int p = 0; p < 4; p++) begin
      if (reg_cnt[p] > CNT_MAX) return 0;
      bytes += int'(reg_cnt[p]) << reg_lg[p];
      blocks += reg_cnt[p];
    end
    if (bytes != HEAP || blocks > NBLK) return 0;
    bytes = 0;
    blocks = 0;
    for (int p = 0; p < 4; p++) begin
      lay_lg[p] = reg_lg[p];
      lay_cnt[p] = reg_cnt[p];
      lay_base[p] = blocks;
      lay_start[p] = bytes;
      blocks += lay_cnt[p];
      bytes += lay_cnt[p] << lay_lg[p];
    end
    return 1;
  endfunction

  function automatic bit locate(int unsigned a, output int unsigned pool,
                                output int unsigned g, output int unsigned off);
    int unsigned rel;
    if (a >= HEAP) return 0;
    for (int p = 0; p < 4; p++) begin
      if (a >= lay_start[p] && a - lay_start[p] < (lay_cnt[p] << lay_lg[p])) begin
        rel = a - lay_start[p];
        g = lay_base[p] + (rel >> lay_lg[p]);
        if (g >= NBLK) return 0;
        pool = p;
        off = rel & ((32'd1 << lay_lg[p]) - 1);
        return 1;
      end
    end
    return 0;
  endfunction

  // Expected result of one command; updates the predicted state
  function automatic alloc_result_t predict_cmd(cmd_e c, int unsigned sz, int unsigned a);
    alloc_result_t r;
    int unsigned p, pool, g, off, slot, aa;
    r.st = ST_OK;
    aa = 0;
    r.fr = 0;
    case (c)
      CMD_ALLOC: begin
        if (sz == 0 || sz > (32'd1 << lay_lg[3])) r.st = ST_INVAL;
        else begin
          p = 0;
          while (p < 4 && sz > (32'd1 << lay_lg[p])) p++;
          if (p >= 4) r.st = ST_INVAL;
          else begin
            while (p < 4 && fill[p] == 0) p++;
            if (p >= 4) r.st = ST_FULL;
            else begin
              slot = lay_base[p] + fill[p] - 1;
              fill[p]--;
              g = (slot < NBLK) ? stk[slot] : 0;
              if (g >= NBLK) g = 0;
              bmap[g] = 0;
              aa = lay_start[p] + ((g - lay_base[p]) << lay_lg[p]);
              live_addrs.push_back(aa);
            end
          end
        end
      end
      CMD_FREE: begin
        if (!locate(a, pool, g, off) || off != 0 || bmap[g]) r.st = ST_INVAL;
        else begin
          slot = lay_base[pool] + fill[pool];
          if (fill[pool] >= lay_cnt[pool] || slot >= NBLK) r.st = ST_INVAL;
          else begin
            stk[slot] = g;
            fill[pool]++;
            bmap[g] = 1;
          end
        end
      end
      CMD_QUERY: begin
        if (!locate(a, pool, g, off)) r.st = ST_INVAL;
        else r.fr = bmap[g];
      end
      default: begin
        if (!latch_layout()) r.st = ST_LAYOUT;
        else begin
          foreach (bmap[i]) bmap[i] = 0;
          for (int q = 0; q < 4; q++) begin
            for (int unsigned k = 0; k < lay_cnt[q]; k++) begin
              slot = lay_base[q] + k;
              g = lay_base[q] + lay_cnt[q] - 1 - k;
              if (slot < NBLK && g < NBLK) begin
                stk[slot] = g;
                bmap[g] = 1;
              end
            end
            fill[q] = lay_cnt[q];
          end
          live_addrs.delete();
        end
      end
    endcase
    r.aa = aa[AADDR_W-1:0];
    return r;
  endfunction

  // Offer one input beat and hold it until taken
  task automatic send(cmd_e c, logic [15:0] sz, logic [15:0] a);
    @(negedge clk);
    in_valid <= 1;
    cmd <= c;
    req_size <= sz;
    block_addr <= a;
    do @(posedge clk); while (!in_ready);
    sb.note(predict_cmd(c, sz, a));
  endtask

  task automatic idle_in(int n);
    @(negedge clk);
    in_valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  // Drain all outstanding results before touching registers
  task automatic wait_idle();
    idle_in(0);
    wait (sb.pend.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_layout(logic [3:0] l0, logic [3:0] l1, logic [3:0] l2,
                              logic [3:0] l3, logic [8:0] c0, logic [8:0] c1,
                              logic [8:0] c2, logic [8:0] c3);
    logic [8:0] v[8];
    v = '{9'(l0), 9'(l1), 9'(l2), 9'(l3), c0, c1, c2, c3};
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we <= 1;
      cfg_idx <= reg_e'(i);
      // Upper bits of a log2 write are don't-care; fill them randomly
      cfg_wdata <= (i < 4) ? {5'($urandom), v[i][3:0]} : v[i];
      if (i < 4) reg_lg[i] = v[i][3:0];
      else reg_cnt[i-4] = v[i];
    end
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // One random command, mostly well-formed against the current layout
  task automatic rand_item();
    int sel, k;
    int unsigned mx;
    sel = $urandom_range(0, 99);
    mx = 32'd1 << lay_lg[3];
    if (mx > 65535) mx = 65535;
    if (sel < 45) begin
      if ($urandom_range(0, 3) == 0) send(CMD_ALLOC, 16'($urandom_range(1, 64)), 16'd0);
      else send(CMD_ALLOC, 16'($urandom_range(1, mx)), 16'($urandom));
    end else if (sel < 80) begin
      if (live_addrs.size() > 0) begin
        k = $urandom_range(0, live_addrs.size() - 1);
        mx = live_addrs[k];
        if ($urandom_range(0, 9) != 0) live_addrs.delete(k);
        send(CMD_FREE, 16'($urandom), 16'(mx));
      end else send(CMD_FREE, 16'($urandom), 16'($urandom_range(0, HEAP - 1)));
    end else if (sel < 92) begin
      send(CMD_QUERY, 16'($urandom), 16'($urandom_range(0, HEAP - 1)));
    end else if (sel < 99) begin
      send(cmd_e'($urandom_range(0, 2)), 16'($urandom), 16'($urandom));
    end else begin
      send(CMD_INIT, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic rand_phase(int n);
    int left;
    left = n;
    while (left > 0) begin
      for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--) begin
        rand_item();
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle_in($urandom_range(0, 8));
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check('{st: status_e'(status), aa: alloc_addr, fr: blk_free});
  end

  // Watchdog on cycles without any accepted beat
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("** multi_pool_block_allocator: FAILED **");
      $finish;
    end
  end

  // Receiver: stall pattern in windows, one long hold-off to back up the block
  initial begin
    int mode;
    bit long_done;
    long_done = 0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk);
        if (!long_done && sb.n_chk >= 150) begin
          long_done = 1;
          out_ready <= 0;
          repeat (400) @(negedge clk);
        end
        out_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) >= mode);
      end
    end
  end

  // Stimulus
  initial begin
    logic [15:0] a;
    reg_lg = '{4'd5, 4'd6, 4'd7, 4'd8};
    reg_cnt = '{9'd128, 9'd64, 9'd32, 9'd16};
    foreach (bmap[i]) bmap[i] = 0;
    foreach (stk[i]) stk[i] = 0;
    foreach (fill[i]) fill[i] = 0;
    void'(latch_layout());
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Before init: all blocks read as allocated
    send(CMD_QUERY, 0, 0);
    send(CMD_ALLOC, 32, 0);
    send(CMD_FREE, 0, 64);
    send(CMD_INIT, 0, 0);
    send(CMD_ALLOC, 0, 0);
    send(CMD_ALLOC, 1, 0);
    send(CMD_ALLOC, 32, 0);
    send(CMD_ALLOC, 33, 0);
    send(CMD_ALLOC, 256, 0);
    send(CMD_ALLOC, 257, 0);
    send(CMD_ALLOC, 16'hFFFF, 16'hFFFF);
    send(CMD_FREE, 0, 16384);
    send(CMD_FREE, 0, 16'hFFFF);
    send(CMD_FREE, 0, 1);
    a = 16'(live_addrs[0]);
    send(CMD_FREE, 0, a);
    send(CMD_FREE, 0, a);
    send(CMD_QUERY, 0, a);
    send(CMD_QUERY, 0, 16383);
    send(CMD_QUERY, 0, 16'hFFFF);
    wait_idle();
    // Layout whose total is wrong, and a count above the pool maximum
    write_layout(4'd5, 4'd6, 4'd7, 4'd8, 9'd511, 9'd64, 9'd32, 9'd16);
    send(CMD_INIT, 0, 0);
    send(CMD_ALLOC, 32, 0);
    wait_idle();
    write_layout(4'd5, 4'd6, 4'd7, 4'd8, 9'd128, 9'd64, 9'd32, 9'd16);
    send(CMD_INIT, 0, 0);
    rand_phase(140);

    // Uniform 64-byte blocks, 64 in each pool
    wait_idle();
    write_layout(4'd6, 4'd6, 4'd6, 4'd6, 9'd64, 9'd64, 9'd64, 9'd64);
    send(CMD_INIT, 0, 0);
    rand_phase(140);

    // One pool holding every block
    wait_idle();
    write_layout(4'd6, 4'd2, 4'd2, 4'd12, 9'd256, 9'd0, 9'd0, 9'd0);
    send(CMD_INIT, 0, 0);
    rand_phase(120);

    // Mixed extremes, non-ascending sizes
    wait_idle();
    write_layout(4'd3, 4'd12, 4'd11, 4'd10, 9'd128, 9'd3, 9'd1, 9'd1);
    send(CMD_INIT, 0, 0);
    rand_phase(140);

    // Four big blocks only
    wait_idle();
    write_layout(4'd2, 4'd12, 4'd12, 4'd12, 9'd0, 9'd4, 9'd0, 9'd0);
    send(CMD_INIT, 0, 0);
    rand_phase(100);

    // Random registers, mostly rejected layouts
    for (int i = 0; i < 3; i++) begin
      wait_idle();
      write_layout(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                   9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
      send(CMD_INIT, 0, 0);
      rand_phase(40);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pend.size() == 0) begin
      $display("** multi_pool_block_allocator: PASSED **");
    end else begin
      $display("** multi_pool_block_allocator: FAILED **");
    end
    $finish;
  end
endmodule
